/* rtl/core/smsm_pkg.sv */
`timescale 1ns / 1ps

package smsm_pkg;

  // modifier and class-set flags kept between strokes
  typedef struct packed {
    logic digit_set;
    logic shift;
    logic caps;
    logic ctrl;
    logic punct;
  } smsm_flags_t;

  typedef enum logic [1:0] {
    SET_LETTERS = 2'd0,
    SET_DIGITS  = 2'd1,
    SET_PUNCT   = 2'd2
  } smsm_class_set_t;

  // special stroke codes
  localparam logic [7:0] CODE_NONE      = 8'h00;
  localparam logic [7:0] CODE_SPACE     = 8'h41; // 'A'
  localparam logic [7:0] CODE_BACKSPACE = 8'h42; // 'B'
  localparam logic [7:0] CODE_NUM_LOCK  = 8'h4e; // 'N'
  localparam logic [7:0] CODE_CONTROL   = 8'h50; // 'P'
  localparam logic [7:0] CODE_NEWLINE   = 8'h52; // 'R'
  localparam logic [7:0] CODE_SHIFT     = 8'h53; // 'S'
  localparam logic [7:0] CODE_CAPS_LOCK = 8'h4c; // 'L'
  localparam logic [7:0] CODE_PERIOD    = 8'h2e; // '.'

  localparam logic [7:0] UPPER_FIRST = 8'h41; // 'A'
  localparam logic [7:0] UPPER_LAST  = 8'h5a; // 'Z'
  localparam logic [7:0] LOWER_FIRST = 8'h61; // 'a'
  localparam logic [7:0] LOWER_LAST  = 8'h7a; // 'z'

  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
  localparam logic [7:0] CTRL_MASK      = 8'h1f;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;

endpackage

/* rtl/core/smsm_step.sv */
`timescale 1ns / 1ps

module smsm_step (
  input  logic [7:0]           class_code,
  input  logic                 no_match,
  input  logic                 stroke_empty,
  input  smsm_pkg::smsm_flags_t flags,
  output smsm_pkg::smsm_flags_t flags_next,
  output logic [7:0]           char_out
);
  import smsm_pkg::*;

  logic is_upper;
  logic is_lower;

  assign is_upper = (class_code >= UPPER_FIRST) && (class_code <= UPPER_LAST);
  assign is_lower = (class_code >= LOWER_FIRST) && (class_code <= LOWER_LAST);

  always_comb begin
    flags_next = flags;
    char_out   = 8'h00;
    if (stroke_empty) begin
      flags_next = flags;
    end else if (no_match) begin
      if (!flags.ctrl) begin
        flags_next.shift = 1'b0;
        flags_next.punct = 1'b0;
        flags_next.ctrl  = 1'b0;
      end
    end else begin
      case (class_code)
        CODE_NONE: begin
          flags_next = flags;
        end
        CODE_SPACE: begin
          char_out = CHAR_SPACE;
        end
        CODE_BACKSPACE: begin
          char_out = CHAR_BACKSPACE;
        end
        CODE_NEWLINE: begin
          char_out = CHAR_NEWLINE;
        end
        CODE_NUM_LOCK: begin
          flags_next.digit_set = ~flags.digit_set;
          flags_next.shift     = 1'b0;
          flags_next.punct     = 1'b0;
          flags_next.ctrl      = 1'b0;
        end
        CODE_CONTROL: begin
          flags_next.ctrl  = ~flags.ctrl;
          flags_next.shift = 1'b0;
          flags_next.punct = 1'b0;
        end
        CODE_SHIFT: begin
          flags_next.punct = 1'b0;
          flags_next.ctrl  = 1'b0;
          // shift, shift again for caps lock, shift once more to release
          if (flags.caps) begin
            flags_next.caps  = 1'b0;
            flags_next.shift = 1'b0;
          end else if (!flags.shift) begin
            flags_next.shift = 1'b1;
          end else begin
            flags_next.caps = 1'b1;
          end
        end
        CODE_CAPS_LOCK: begin
          flags_next.caps = ~flags.caps;
        end
        CODE_PERIOD: begin
          if (flags.punct) begin
            flags_next.punct = 1'b0;
            char_out         = CODE_PERIOD;
          end else begin
            flags_next.punct = 1'b1;
            flags_next.ctrl  = 1'b0;
            flags_next.shift = 1'b0;
          end
        end
        default: begin
          if (!is_upper) begin
            if (flags.ctrl) begin
              // control passes non-letters through untouched
              if (is_lower) begin
                char_out         = class_code & CTRL_MASK;
                flags_next.shift = 1'b0;
                flags_next.punct = 1'b0;
                flags_next.ctrl  = 1'b0;
              end else begin
                char_out = class_code;
              end
            end else begin
              if ((flags.caps ^ flags.shift) && is_lower) begin
                char_out = class_code - CASE_OFFSET;
              end else begin
                char_out = class_code;
              end
              flags_next.shift = 1'b0;
              flags_next.punct = 1'b0;
              flags_next.ctrl  = 1'b0;
            end
          end
        end
      endcase
    end
  end

endmodule

/* rtl/core/stroke_modifier_state_machine.sv */
`timescale 1ns / 1ps
// result: registered; an accepted input transaction shows its result on out_* in the next cycle
// throughput: one stroke per cycle unless a result waits with out_tready low;
//   a waiting result does not block input if out_tready frees it in the same cycle
// reset (rst_n low, synchronous): all modifier flags clear, letters set selected,
//   no result pending

module stroke_modifier_state_machine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,  // [7:0] class_code
  input  logic [1:0]  in_tuser,  // [0] no_match, [1] stroke_empty
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // [7:0] out_char, [9:8] next_class_set,
                                 // [10] caps_lock_on, [11] shift_pending,
                                 // [12] control_pending, [15:13] zero
);
  import smsm_pkg::*;

  smsm_flags_t     flags_r;
  smsm_flags_t     flags_nxt;
  logic [7:0]      char_nxt;
  smsm_class_set_t set_nxt;
  logic [15:0]     out_data_r;
  logic            out_valid_r;
  logic            in_accept;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  smsm_step u_step (
    .class_code   (in_tdata),
    .no_match     (in_tuser[0]),
    .stroke_empty (in_tuser[1]),
    .flags        (flags_r),
    .flags_next   (flags_nxt),
    .char_out     (char_nxt)
  );

  always_comb begin
    if (flags_nxt.punct) begin
      set_nxt = SET_PUNCT;
    end else if (flags_nxt.digit_set) begin
      set_nxt = SET_DIGITS;
    end else begin
      set_nxt = SET_LETTERS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        flags_r     <= flags_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= {3'b000, flags_nxt.ctrl, flags_nxt.shift, flags_nxt.caps,
                     set_nxt, char_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
